>>> rtl/filter_life_monitor_defines.svh
// Assertion macros for the filter life monitor.
// Requires clk and rst in the scope of each use.
`ifndef FILTER_LIFE_MONITOR_DEFINES_SVH
`define FILTER_LIFE_MONITOR_DEFINES_SVH

// Same-cycle implication.
`define FLM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/flm_pkg.sv
// Filter life monitor package: types, constants and the microcode ROM.
// No dependencies.
`timescale 1ns / 1ps

package flm_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int STEP_W      = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_HEPA_LIFE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CARBON_LIFE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WARNING       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CRITICAL      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_POLL          = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SAVE_INTERVAL = 3'd5;

  localparam logic [1:0]  LEVEL_OK         = 2'd0;
  localparam logic [1:0]  LEVEL_WARNING    = 2'd1;
  localparam logic [1:0]  LEVEL_CRITICAL   = 2'd2;
  localparam logic [11:0] SECONDS_PER_HOUR = 12'd3600;
  localparam logic [6:0]  FULL_PERCENT     = 7'd100;
  localparam logic [2:0]  QBIT_TOP         = 3'd6;

  typedef logic [2:0] op_t;
  localparam op_t OP_NOP    = 3'd0;
  localparam op_t OP_ACCEPT = 3'd1;
  localparam op_t OP_PREP   = 3'd2;
  localparam op_t OP_CHECK  = 3'd3;
  localparam op_t OP_DIV    = 3'd4;
  localparam op_t OP_FINISH = 3'd5;
  localparam op_t OP_EMIT   = 3'd6;

  typedef logic [2:0] jc_t;
  localparam jc_t JC_NEVER     = 3'd0;
  localparam jc_t JC_ALWAYS    = 3'd1;
  localparam jc_t JC_NO_INPUT  = 3'd2;
  localparam jc_t JC_OVER_LIFE = 3'd3;
  localparam jc_t JC_MORE      = 3'd4;
  localparam jc_t JC_FIRST     = 3'd5;
  localparam jc_t JC_OUT_BUSY  = 3'd6;

  localparam logic [STEP_W-1:0] ST_ACCEPT = 3'd0;
  localparam logic [STEP_W-1:0] ST_PREP   = 3'd1;
  localparam logic [STEP_W-1:0] ST_CHECK  = 3'd2;
  localparam logic [STEP_W-1:0] ST_DIV    = 3'd3;
  localparam logic [STEP_W-1:0] ST_FINISH = 3'd4;
  localparam logic [STEP_W-1:0] ST_EMIT   = 3'd5;
  localparam logic [STEP_W-1:0] ST_RETURN = 3'd6;

  typedef struct packed {
    op_t               op;
    jc_t               jc;
    logic [STEP_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic over_life;
    logic more;
    logic first;
  } status_t;

  typedef struct packed {
    logic [15:0] hepa_life;
    logic [15:0] carbon_life;
    logic [6:0]  warning;
    logic [6:0]  critical;
    logic [7:0]  poll;
    logic [15:0] save_interval;
  } cfg_t;

  typedef struct packed {
    logic [6:0]  hepa_condition;
    logic [1:0]  hepa_level;
    logic [6:0]  carbon_condition;
    logic [1:0]  carbon_level;
    logic [31:0] run_total;
    logic        save_now;
  } result_t;

  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t w;
    case (step)
      ST_ACCEPT: w = '{op: OP_ACCEPT, jc: JC_NO_INPUT,  target: ST_ACCEPT};
      ST_PREP:   w = '{op: OP_PREP,   jc: JC_NEVER,     target: ST_ACCEPT};
      ST_CHECK:  w = '{op: OP_CHECK,  jc: JC_OVER_LIFE, target: ST_FINISH};
      ST_DIV:    w = '{op: OP_DIV,    jc: JC_MORE,      target: ST_DIV};
      ST_FINISH: w = '{op: OP_FINISH, jc: JC_FIRST,     target: ST_PREP};
      ST_EMIT:   w = '{op: OP_EMIT,   jc: JC_OUT_BUSY,  target: ST_EMIT};
      ST_RETURN: w = '{op: OP_NOP,    jc: JC_ALWAYS,    target: ST_ACCEPT};
      default:   w = '{op: OP_NOP,    jc: JC_ALWAYS,    target: ST_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/flm_channels.sv
// Input and result channel interfaces for the filter life monitor.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface flm_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [6:0]  fan_percent;
  logic [31:0] load_value;

  modport source(output valid, command, fan_percent, load_value, input ready);
  modport sink(input valid, command, fan_percent, load_value, output ready);
endinterface

interface flm_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  hepa_condition;
  logic [1:0]  hepa_level;
  logic [6:0]  carbon_condition;
  logic [1:0]  carbon_level;
  logic [31:0] run_total;
  logic        save_now;

  modport source(output valid, hepa_condition, hepa_level, carbon_condition, carbon_level,
                 run_total, save_now, input ready);
  modport sink(input valid, hepa_condition, hepa_level, carbon_condition, carbon_level,
               run_total, save_now, output ready);
endinterface

>>> rtl/flm_sequencer.sv
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on flm_pkg.
`timescale 1ns / 1ps

module flm_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  flm_pkg::status_t status,
  output flm_pkg::ctl_t    ctl
);
  import flm_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              take;

  assign ctl = ucode(step);

  always_comb begin
    case (ctl.jc)
      JC_NEVER:     take = 1'b0;
      JC_ALWAYS:    take = 1'b1;
      JC_NO_INPUT:  take = !status.in_valid;
      JC_OVER_LIFE: take = status.over_life;
      JC_MORE:      take = status.more;
      JC_FIRST:     take = status.first;
      JC_OUT_BUSY:  take = status.out_busy;
      default:      take = 1'b1;
    endcase
    step_next = take ? ctl.target : step + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_ACCEPT;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> rtl/flm_datapath.sv
// Datapath: run counters, life product, restoring divide and level compare.
// Depends on flm_pkg and filter_life_monitor_defines.svh.
`timescale 1ns / 1ps
`include "filter_life_monitor_defines.svh"

module flm_datapath (
  input  logic             clk,
  input  logic             rst,
  input  flm_pkg::ctl_t    ctl,
  input  flm_pkg::cfg_t    cfg,
  input  logic             in_valid,
  input  logic             command,
  input  logic [6:0]       fan_percent,
  input  logic [31:0]      load_value,
  input  logic             out_busy,
  output flm_pkg::status_t status,
  output flm_pkg::result_t result
);
  import flm_pkg::*;

  logic [31:0] total;
  logic [16:0] since;
  logic        save;
  logic        first;
  logic [27:0] life;
  logic [34:0] prod;
  logic [34:0] rem;
  logic [6:0]  quot;
  logic [2:0]  qbit;
  logic        over;
  logic [6:0]  hepa_cond;
  logic [1:0]  hepa_lvl;
  logic [6:0]  carbon_cond;
  logic [1:0]  carbon_lvl;

  logic [15:0] hours;
  logic        over_life;
  logic [34:0] divisor;
  logic        fits;
  logic [6:0]  cond_calc;
  logic [1:0]  lvl_calc;
  logic [32:0] sum;
  logic [16:0] since_sum;

  always_comb begin
    hours     = first ? cfg.hepa_life : cfg.carbon_life;
    over_life = total >= 32'(life);
    divisor   = 35'(life) << qbit;
    fits      = rem >= divisor;
    cond_calc = over ? 7'd0 : FULL_PERCENT - quot;
    if (cond_calc <= cfg.critical) begin
      lvl_calc = LEVEL_CRITICAL;
    end else if (cond_calc <= cfg.warning) begin
      lvl_calc = LEVEL_WARNING;
    end else begin
      lvl_calc = LEVEL_OK;
    end
    sum       = {1'b0, total} + 33'(cfg.poll);
    since_sum = since + 17'(cfg.poll);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      since <= '0;
      save  <= 1'b0;
      first <= 1'b1;
    end else begin
      case (ctl.op)
        OP_ACCEPT: begin
          if (in_valid) begin
            first <= 1'b1;
            save  <= 1'b0;
            if (command) begin
              total <= load_value;
            end else if (fan_percent != 7'd0) begin
              total <= sum[32] ? '1 : sum[31:0];
              if (since_sum >= 17'(cfg.save_interval)) begin
                save  <= 1'b1;
                since <= '0;
              end else begin
                since <= since_sum;
              end
            end
          end
        end
        OP_FINISH: begin
          first <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // product only matters below rated life, where it fits 35 bits
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_PREP: begin
        life <= 28'(hours) * 28'(SECONDS_PER_HOUR);
        prod <= 35'(total) * 35'(FULL_PERCENT);
        qbit <= QBIT_TOP;
        quot <= '0;
      end
      OP_CHECK: begin
        over <= over_life;
        rem  <= prod;
      end
      OP_DIV: begin
        if (fits) begin
          rem <= rem - divisor;
        end
        quot <= {quot[5:0], fits};
        qbit <= qbit - 3'd1;
      end
      OP_FINISH: begin
        if (first) begin
          hepa_cond <= cond_calc;
          hepa_lvl  <= lvl_calc;
        end else begin
          carbon_cond <= cond_calc;
          carbon_lvl  <= lvl_calc;
        end
      end
      default: ;
    endcase
  end

  assign status = '{in_valid: in_valid, out_busy: out_busy, over_life: over_life,
                    more: qbit != 3'd0, first: first};

  assign result = '{hepa_condition: hepa_cond, hepa_level: hepa_lvl,
                    carbon_condition: carbon_cond, carbon_level: carbon_lvl,
                    run_total: total, save_now: save};

  `FLM_ASSERT_NEXT(a_load_sets_total, ctl.op == OP_ACCEPT && in_valid && command, total == $past(load_value), "load transaction did not set run total")
  `FLM_ASSERT_NEXT(a_tick_no_decrease, ctl.op == OP_ACCEPT && in_valid && !command, total >= $past(total), "tick transaction decreased run total")
  `FLM_ASSERT_SAME(a_quot_range, ctl.op == OP_FINISH && !over, quot < FULL_PERCENT, "quotient out of range below rated life")

endmodule

>>> rtl/filter_life_monitor.sv
// Channel   Dir  Contents
// in_ch     in   command, fan_percent, load_value
// out_ch    out  hepa/carbon condition and level, run_total, save_now
// cfg_*     in   register write: cfg_we, cfg_index, cfg_data
//
// An item runs through accept, then per filter a multiply step, a compare step,
// seven restoring divide steps (skipped when a filter is past rated life) and
// a finish step, then emit and return.
// Synchronous active-high reset clears counters, sequencer and output valid.
// The result sits in an output register; a stalled sink holds the sequencer
// at the emit step only.
// Top level; depends on flm_pkg, flm_channels, flm_sequencer, flm_datapath.
`timescale 1ns / 1ps

module filter_life_monitor (
  input  logic                               clk,
  input  logic                               rst,
  flm_in_if.sink                             in_ch,
  flm_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [flm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [flm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import flm_pkg::*;

  cfg_t    cfg;
  ctl_t    ctl;
  status_t status;
  result_t result;
  result_t hold;
  logic    out_valid;
  logic    out_busy;
  logic    emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{hepa_life: 16'd2000, carbon_life: 16'd1000, warning: 7'd20,
               critical: 7'd5, poll: 8'd5, save_interval: 16'd60};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEPA_LIFE:     cfg.hepa_life     <= cfg_data;
        REG_CARBON_LIFE:   cfg.carbon_life   <= cfg_data;
        REG_WARNING:       cfg.warning       <= cfg_data[6:0];
        REG_CRITICAL:      cfg.critical      <= cfg_data[6:0];
        REG_POLL:          cfg.poll          <= cfg_data[7:0];
        REG_SAVE_INTERVAL: cfg.save_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  flm_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctl    (ctl)
  );

  flm_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cfg         (cfg),
    .in_valid    (in_ch.valid),
    .command     (in_ch.command),
    .fan_percent (in_ch.fan_percent),
    .load_value  (in_ch.load_value),
    .out_busy    (out_busy),
    .status      (status),
    .result      (result)
  );

  assign in_ch.ready = ctl.op == OP_ACCEPT;
  assign out_busy    = out_valid && !out_ch.ready;
  assign emit        = ctl.op == OP_EMIT && !out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hold <= result;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.hepa_condition   = hold.hepa_condition;
  assign out_ch.hepa_level       = hold.hepa_level;
  assign out_ch.carbon_condition = hold.carbon_condition;
  assign out_ch.carbon_level     = hold.carbon_level;
  assign out_ch.run_total        = hold.run_total;
  assign out_ch.save_now         = hold.save_now;

endmodule
